// File: hw/rtl/ray_yz_rectangle_intersect_assert.svh
// Assertion macros shared by the ray/rectangle intersection RTL.
`ifndef RAY_YZ_RECTANGLE_INTERSECT_ASSERT_SVH
`define RAY_YZ_RECTANGLE_INTERSECT_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define RYZR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define RYZR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ryzr_pkg.sv
// Shared types and constants of the ray/rectangle intersection block.
package ryzr_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Queue between front and back; the depth must be a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  localparam logic [16:0] TEX_MAX = 17'h1FFFF;

  // Configuration register indexes.
  localparam logic [2:0] REG_PLANE_X = 3'd0;
  localparam logic [2:0] REG_Y_LOW   = 3'd1;
  localparam logic [2:0] REG_Y_HIGH  = 3'd2;
  localparam logic [2:0] REG_Z_LOW   = 3'd3;
  localparam logic [2:0] REG_Z_HIGH  = 3'd4;

  typedef struct packed {
    logic signed [31:0] plane_x;
    logic signed [31:0] y_low;
    logic signed [31:0] y_high;
    logic signed [31:0] z_low;
    logic signed [31:0] z_high;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] t_lower;
    logic signed [31:0] t_upper;
  } ray_t;

  typedef struct packed {
    logic               hit_flag;
    logic signed [31:0] t_hit;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic        [16:0] tex_u;
    logic        [16:0] tex_v;
    logic               front_face;
  } hit_t;

  // One classified ray as it waits for the back end.
  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] t;
    logic               t_ok;
  } fq_t;

endpackage

// File: hw/rtl/ryzr_front.sv
// Front end: accepts rays, divides out the plane parameter t and range-checks it.
module ryzr_front #(
  parameter int FRAC_BITS = ryzr_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  ryzr_pkg::cfg_t cfg,
  input  logic           ray_valid,
  output logic           ray_stall,
  input  ryzr_pkg::ray_t ray,
  output logic           push,
  output ryzr_pkg::fq_t  push_data,
  input  logic           full
);
  import ryzr_pkg::*;

  // Width of the magnitude of (plane_x - origin_x) scaled by 2^FRAC_BITS.
  localparam int NM = 33 + FRAC_BITS;

  logic            en;
  logic            vld  [NM+1];
  ray_t            pay  [NM+1];
  logic [31:0]     rem  [NM+1];
  logic [NM-1:0]   nq   [NM+1];
  logic [31:0]     dm   [NM+1];
  logic            neg  [NM+1];

  logic            cv;
  fq_t             cdata;

  logic signed [32:0] diff;
  logic        [32:0] mag;
  logic signed [NM:0] tw;
  logic signed [NM:0] tlo_w;
  logic signed [NM:0] thi_w;
  logic               t_ok;

  // The whole front holds when the classified ray cannot enter the queue.
  assign en        = !(cv && full);
  assign ray_stall = !en;
  assign push      = cv && !full;
  assign push_data = cdata;

  assign diff = {cfg.plane_x[31], cfg.plane_x} - {ray.origin_x[31], ray.origin_x};
  assign mag  = diff[32] ? (33'd0 - diff) : diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= ray_valid;
    end
    if (en) begin
      pay[0] <= ray;
      rem[0] <= '0;
      nq[0]  <= {mag, {FRAC_BITS{1'b0}}};
      dm[0]  <= ray.dir_x[31] ? (32'd0 - ray.dir_x) : ray.dir_x;
      neg[0] <= diff[32] ^ ray.dir_x[31];
    end
  end

  // One restoring division step per stage, most significant quotient bit first.
  for (genvar k = 1; k <= NM; k++) begin : g_div
    logic [32:0] tmp;
    logic [32:0] sub;
    logic        ge;

    assign tmp = {rem[k-1], nq[k-1][NM-1]};
    assign sub = tmp - {1'b0, dm[k-1]};
    assign ge  = tmp >= {1'b0, dm[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
      if (en) begin
        pay[k] <= pay[k-1];
        rem[k] <= ge ? sub[31:0] : tmp[31:0];
        nq[k]  <= {nq[k-1][NM-2:0], ge};
        dm[k]  <= dm[k-1];
        neg[k] <= neg[k-1];
      end
    end
  end

  assign tw    = neg[NM] ? ((NM+1)'(0) - {1'b0, nq[NM]}) : {1'b0, nq[NM]};
  assign tlo_w = {{(NM-31){pay[NM].t_lower[31]}}, pay[NM].t_lower};
  assign thi_w = {{(NM-31){pay[NM].t_upper[31]}}, pay[NM].t_upper};
  assign t_ok  = (pay[NM].dir_x != 32'sd0) && (tw >= tlo_w) && (tw <= thi_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= 1'b0;
    end else if (en) begin
      cv <= vld[NM];
    end
    if (en) begin
      cdata.origin_x <= pay[NM].origin_x;
      cdata.origin_y <= pay[NM].origin_y;
      cdata.origin_z <= pay[NM].origin_z;
      cdata.dir_x    <= pay[NM].dir_x;
      cdata.dir_y    <= pay[NM].dir_y;
      cdata.dir_z    <= pay[NM].dir_z;
      cdata.t        <= tw[31:0];
      cdata.t_ok     <= t_ok;
    end
  end

endmodule

// File: hw/rtl/ryzr_queue.sv
// Small register queue that decouples the front end from the back end.
`include "ray_yz_rectangle_intersect_assert.svh"

module ryzr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ryzr_pkg::fq_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output ryzr_pkg::fq_t head
);
  import ryzr_pkg::*;

  fq_t                 mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp;
  logic [QUEUE_AW-1:0] rp;
  logic [QUEUE_AW:0]   cnt;

  assign full     = cnt == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign nonempty = cnt != '0;
  assign head     = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
    if (push) begin
      mem[wp] <= push_data;
    end
  end

  `RYZR_ASSERT_SAME(a_push_room, push, cnt < (QUEUE_AW+1)'(QUEUE_DEPTH), "queue overrun")
  `RYZR_ASSERT_SAME(a_pop_data, pop, cnt != '0, "queue underrun")
  `RYZR_ASSERT_NEXT(a_count_up, push && !pop, cnt == $past(cnt) + 1'b1, "queue count lost")

endmodule

// File: hw/rtl/ryzr_back.sv
// Back end: hit point, bounds check, texture division and the output register.
`include "ray_yz_rectangle_intersect_assert.svh"

module ryzr_back #(
  parameter int FRAC_BITS = ryzr_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  ryzr_pkg::cfg_t cfg,
  input  logic           nonempty,
  input  ryzr_pkg::fq_t  head,
  output logic           pop,
  output logic           hit_valid,
  input  logic           hit_stall,
  output ryzr_pkg::hit_t hit
);
  import ryzr_pkg::*;

  localparam int SW = 65 - FRAC_BITS;   // width of origin + (t*dir >> FRAC_BITS)
  localparam int TS = FRAC_BITS + 1;    // texture quotient bits, one per stage

  typedef struct packed {
    logic               hit;
    logic signed [31:0] t;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               ff;
    logic               ypos;
    logic               zpos;
  } tp_t;

  logic en;

  // Multiply stage.
  logic               mv;
  fq_t                md;
  logic signed [63:0] px;
  logic signed [63:0] py;
  logic signed [63:0] pz;

  // Sum stage.
  logic                 av;
  fq_t                  ad;
  logic signed [SW-1:0] xs;
  logic signed [SW-1:0] ys;
  logic signed [SW-1:0] zs;

  logic signed [63:0] shx;
  logic signed [63:0] shy;
  logic signed [63:0] shz;

  // Check stage inputs.
  logic signed [SW-1:0] ylo_w, yhi_w, zlo_w, zhi_w, imax_w, imin_w;
  logic signed [SW-1:0] ynum, znum;
  logic signed [32:0]   yspan, zspan;
  logic signed [31:0]   xsat;
  tp_t                  cp;

  // Texture division stages; index 0 is the check stage.
  logic        qv [TS+1];
  tp_t         qp [TS+1];
  logic [31:0] ry [TS+1];
  logic [31:0] sy [TS+1];
  logic [TS-1:0] qy [TS+1];
  logic [31:0] rz [TS+1];
  logic [31:0] sz [TS+1];
  logic [TS-1:0] qz [TS+1];

  hit_t res;

  function automatic logic [16:0] tex_sat(input logic [TS-1:0] q);
    logic [TS+16:0] w;
    logic [TS+16:0] lim;
    w   = {17'd0, q};
    lim = {{TS{1'b0}}, TEX_MAX};
    return (w > lim) ? TEX_MAX : w[16:0];
  endfunction

  assign en  = !hit_valid || !hit_stall;
  assign pop = en && nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (en) begin
      mv <= nonempty;
    end
    if (en) begin
      md <= head;
      px <= 64'(head.t) * 64'(head.dir_x);
      py <= 64'(head.t) * 64'(head.dir_y);
      pz <= 64'(head.t) * 64'(head.dir_z);
    end
  end

  // Arithmetic shift is the floor of the scaled product.
  assign shx = px >>> FRAC_BITS;
  assign shy = py >>> FRAC_BITS;
  assign shz = pz >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      av <= 1'b0;
    end else if (en) begin
      av <= mv;
    end
    if (en) begin
      ad <= md;
      xs <= {{(SW-32){md.origin_x[31]}}, md.origin_x} + shx[SW-1:0];
      ys <= {{(SW-32){md.origin_y[31]}}, md.origin_y} + shy[SW-1:0];
      zs <= {{(SW-32){md.origin_z[31]}}, md.origin_z} + shz[SW-1:0];
    end
  end

  assign ylo_w  = {{(SW-32){cfg.y_low[31]}},  cfg.y_low};
  assign yhi_w  = {{(SW-32){cfg.y_high[31]}}, cfg.y_high};
  assign zlo_w  = {{(SW-32){cfg.z_low[31]}},  cfg.z_low};
  assign zhi_w  = {{(SW-32){cfg.z_high[31]}}, cfg.z_high};
  assign imax_w = {{(SW-32){1'b0}}, 32'h7FFF_FFFF};
  assign imin_w = {{(SW-32){1'b1}}, 32'h8000_0000};

  assign ynum  = ys - ylo_w;
  assign znum  = zs - zlo_w;
  assign yspan = {cfg.y_high[31], cfg.y_high} - {cfg.y_low[31], cfg.y_low};
  assign zspan = {cfg.z_high[31], cfg.z_high} - {cfg.z_low[31], cfg.z_low};

  assign xsat = (xs > imax_w) ? 32'sh7FFF_FFFF :
                (xs < imin_w) ? 32'sh8000_0000 : xs[31:0];

  always_comb begin
    cp.hit  = ad.t_ok && (ys >= ylo_w) && (ys <= yhi_w) && (zs >= zlo_w) && (zs <= zhi_w);
    cp.t    = ad.t;
    cp.x    = xsat;
    cp.y    = ys[31:0];
    cp.z    = zs[31:0];
    cp.ff   = ad.dir_x[31];
    cp.ypos = !yspan[32] && (yspan != 33'sd0);
    cp.zpos = !zspan[32] && (zspan != 33'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qv[0] <= 1'b0;
    end else if (en) begin
      qv[0] <= av;
    end
    if (en) begin
      qp[0] <= cp;
      ry[0] <= ynum[31:0];
      sy[0] <= yspan[31:0];
      qy[0] <= '0;
      rz[0] <= znum[31:0];
      sz[0] <= zspan[31:0];
      qz[0] <= '0;
    end
  end

  // The first step weighs 2^FRAC_BITS; each later step doubles the remainder.
  for (genvar k = 1; k <= TS; k++) begin : g_tex
    logic [32:0] ty, tz, dy, dz;
    logic        gy, gz;

    if (k == 1) begin : g_first
      assign ty = {1'b0, ry[k-1]};
      assign tz = {1'b0, rz[k-1]};
    end else begin : g_rest
      assign ty = {ry[k-1], 1'b0};
      assign tz = {rz[k-1], 1'b0};
    end

    assign gy = ty >= {1'b0, sy[k-1]};
    assign gz = tz >= {1'b0, sz[k-1]};
    assign dy = ty - {1'b0, sy[k-1]};
    assign dz = tz - {1'b0, sz[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        qv[k] <= 1'b0;
      end else if (en) begin
        qv[k] <= qv[k-1];
      end
      if (en) begin
        qp[k] <= qp[k-1];
        ry[k] <= gy ? dy[31:0] : ty[31:0];
        rz[k] <= gz ? dz[31:0] : tz[31:0];
        sy[k] <= sy[k-1];
        sz[k] <= sz[k-1];
        qy[k] <= {qy[k-1][TS-2:0], gy};
        qz[k] <= {qz[k-1][TS-2:0], gz};
      end
    end
  end

  always_comb begin
    res = '0;
    if (qp[TS].hit) begin
      res.hit_flag   = 1'b1;
      res.t_hit      = qp[TS].t;
      res.point_x    = qp[TS].x;
      res.point_y    = qp[TS].y;
      res.point_z    = qp[TS].z;
      res.tex_u      = qp[TS].ypos ? tex_sat(qy[TS]) : 17'd0;
      res.tex_v      = qp[TS].zpos ? tex_sat(qz[TS]) : 17'd0;
      res.front_face = qp[TS].ff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= 1'b0;
    end else if (en) begin
      hit_valid <= qv[TS];
    end
    if (en) begin
      hit <= res;
    end
  end

  `RYZR_ASSERT_SAME(a_miss_zero, hit_valid && !hit.hit_flag, hit == '0, "miss with data")
  `RYZR_ASSERT_SAME(a_hit_in_y, hit_valid && hit.hit_flag, (hit.point_y >= cfg.y_low) && (hit.point_y <= cfg.y_high), "hit outside y bounds")
  `RYZR_ASSERT_SAME(a_hit_in_z, hit_valid && hit.hit_flag, (hit.point_z >= cfg.z_low) && (hit.point_z <= cfg.z_high), "hit outside z bounds")

endmodule

// File: hw/rtl/ray_yz_rectangle_intersect.sv
// Top level of the ray versus x-plane rectangle intersection block.
//
//   Channel  Handshake             Payload
//   ray      ray_valid/ray_stall   ray  (ryzr_pkg::ray_t)
//   hit      hit_valid/hit_stall   hit  (ryzr_pkg::hit_t)
//   config   wr_en                 wr_index, wr_data
//
// One ray transaction is taken per cycle while ray_stall is low, and one hit
// transaction leaves per ray. Each ray passes the divider stages of the front,
// the queue and the stages of the back; the one-bit-per-stage dividers for t
// and for the texture coordinates set the depth. Reset clears the configuration
// registers and all valid bits; no clearing pass is needed. A stalled hit
// transaction freezes the back end, the four-entry queue keeps the front
// running, and once it fills the front freezes and ray_stall rises.
module ray_yz_rectangle_intersect #(
  parameter int FRAC_BITS = ryzr_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           ray_valid,
  output logic           ray_stall,
  input  ryzr_pkg::ray_t ray,
  output logic           hit_valid,
  input  logic           hit_stall,
  output ryzr_pkg::hit_t hit,
  input  logic           wr_en,
  input  logic [2:0]     wr_index,
  input  logic [31:0]    wr_data
);
  import ryzr_pkg::*;

  cfg_t cfg;
  logic push;
  fq_t  push_data;
  logic full;
  logic pop;
  logic nonempty;
  fq_t  head;

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_PLANE_X: cfg.plane_x <= wr_data;
        REG_Y_LOW:   cfg.y_low   <= wr_data;
        REG_Y_HIGH:  cfg.y_high  <= wr_data;
        REG_Z_LOW:   cfg.z_low   <= wr_data;
        REG_Z_HIGH:  cfg.z_high  <= wr_data;
        default: ;
      endcase
    end
  end

  // The front divides out t and decides whether the ray can hit at all.
  ryzr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ray_valid (ray_valid),
    .ray_stall (ray_stall),
    .ray       (ray),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  ryzr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .nonempty  (nonempty),
    .head      (head)
  );

  // The back forms the hit point, checks the bounds and derives texture coordinates.
  ryzr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .nonempty  (nonempty),
    .head      (head),
    .pop       (pop),
    .hit_valid (hit_valid),
    .hit_stall (hit_stall),
    .hit       (hit)
  );

endmodule
